// File: rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the box filter downscaler.
// ----------------------------------------------------------------------------
package bfd_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_SRC_WIDTH  = 8'd0;
  localparam logic [7:0] CFG_SRC_HEIGHT = 8'd1;
  localparam logic [7:0] CFG_CHANNELS   = 8'd2;
  localparam logic [7:0] CFG_MAX_DIM    = 8'd3;

  // setup divider operand widths
  localparam int unsigned DIV_NW = 27;
  localparam int unsigned DIV_DW = 14;

  // quotient bits of a box average
  localparam int unsigned AVG_STEPS = 8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic acc_en;
    logic init;
    logic div_step;
  } lane_ctrl_t;

endpackage

// File: rtl/box_filter_image_downscale_core.sv
// ----------------------------------------------------------------------------
// box_filter_image_downscale_core
// Area-average downscaler for a raster pixel stream of up to four channels.
// ----------------------------------------------------------------------------
// A pass-through pixel is accepted, then goes to the output register. A pixel
// inside a box is accepted, then a read-modify-write updates the column sums;
// the pixel that completes a box also passes the four channel lanes, which run
// an 8-step serial average in parallel before the merged result goes to the
// output register. After reset and after each configuration write the input
// stays stalled while one serial divider works out the output size, the box
// steps and the box edges at the current position in six passes.
// Column sums live in RAMs that need no clearing: a box's first row writes them.
module box_filter_image_downscale_core #(
  parameter int unsigned MAX_SRC_DIM  = 4096,
  parameter int unsigned MAX_OUT_DIM  = 2048,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // chan_a, chan_b, chan_c, chan_d
  input  logic [0:0]  s_axis_tuser_i,  // frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,  // res_a, res_b, res_c, res_d, res_col,
                                       // res_row, scaled_width, scaled_height
  output logic        m_axis_tlast_o,  // frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bfd_pkg::*;

  localparam int unsigned AW = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;

  // configuration
  logic [12:0] cfg_w_q, cfg_h_q;
  logic [2:0]  cfg_n_q;
  logic [11:0] cfg_md_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= 13'd1024;
      cfg_h_q  <= 13'd768;
      cfg_n_q  <= 3'd4;
      cfg_md_q <= 12'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:  cfg_w_q  <= cfg_data_i[12:0];
        CFG_SRC_HEIGHT: cfg_h_q  <= cfg_data_i[12:0];
        CFG_CHANNELS:   cfg_n_q  <= cfg_data_i[2:0];
        CFG_MAX_DIM:    cfg_md_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic [12:0] w_c, h_c, long_c;
  logic [11:0] md_c;
  logic [2:0]  nch_c;
  logic        scale_c;

  always_comb begin
    w_c = (cfg_w_q == 13'd0) ? 13'd1 : cfg_w_q;
    if ({2'b0, w_c} > 15'(MAX_SRC_DIM)) w_c = 13'(MAX_SRC_DIM);
    h_c = (cfg_h_q == 13'd0) ? 13'd1 : cfg_h_q;
    if ({2'b0, h_c} > 15'(MAX_SRC_DIM)) h_c = 13'(MAX_SRC_DIM);
    nch_c = (cfg_n_q == 3'd0) ? 3'd1 : cfg_n_q;
    if (nch_c > 3'(MAX_CHANNELS)) nch_c = 3'(MAX_CHANNELS);
    md_c = ({3'b0, cfg_md_q} > 15'(MAX_OUT_DIM)) ? 12'(MAX_OUT_DIM) : cfg_md_q;
    long_c  = (w_c > h_c) ? w_c : h_c;
    scale_c = (md_c != 12'd0) && (long_c > {1'b0, md_c});
  end

  // pixel position state
  state_e      state_q, state_d;
  logic [11:0] src_col_q, src_row_q, dst_col_q, dst_row_q;
  logic        first_q;
  logic [13:0] cstart_q, cend_q, rend_q;
  logic [12:0] crem_q, rrem_q;

  // size setup: six passes through the serial divider
  logic              setup_pend_q, setup_busy_q;
  logic [2:0]        step_q, start_step;
  logic              div_start, div_done, save;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den, div_rem;
  logic [25:0]       wprod, hprod;
  logic [24:0]       cprod, rprod;
  logic              scale_q;
  logic [12:0]       dw_q, dh_q, qw_q, rw_q, qh_q, rh_q;
  logic [13:0]       sv_start, sv_sum, sv_end;
  logic [12:0]       sv_q, sv_r, sv_den, sv_rem;
  logic              sv_carry;

  assign wprod      = 26'(w_c) * 26'(md_c);
  assign hprod      = 26'(h_c) * 26'(md_c);
  assign cprod      = 25'(dst_col_q) * 25'(w_c);
  assign rprod      = 25'(dst_row_q) * 25'(h_c);
  assign save       = div_done && !setup_pend_q;
  assign div_start  = setup_pend_q || (save && step_q != 3'd5);
  assign start_step = setup_pend_q ? 3'd0 : step_q + 3'd1;

  always_comb begin
    case (start_step)
      3'd0: begin
        div_num = {wprod, 1'b0} + DIV_NW'(long_c);
        div_den = {long_c, 1'b0};
      end
      3'd1: begin
        div_num = {hprod, 1'b0} + DIV_NW'(long_c);
        div_den = {long_c, 1'b0};
      end
      3'd2: begin
        div_num = DIV_NW'(w_c);
        div_den = DIV_DW'(dw_q);
      end
      3'd3: begin
        div_num = DIV_NW'(h_c);
        div_den = DIV_DW'(dh_q);
      end
      3'd4: begin
        div_num = DIV_NW'(cprod);
        div_den = DIV_DW'(dw_q);
      end
      default: begin
        div_num = DIV_NW'(rprod);
        div_den = DIV_DW'(dh_q);
      end
    endcase
  end

  // box edges at the current position, a start far outside the image stays outside
  always_comb begin
    sv_q     = (step_q == 3'd4) ? qw_q : qh_q;
    sv_r     = (step_q == 3'd4) ? rw_q : rh_q;
    sv_den   = (step_q == 3'd4) ? dw_q : dh_q;
    sv_start = (div_quo > DIV_NW'(4096)) ? 14'd4097 : div_quo[13:0];
    sv_sum   = {1'b0, div_rem[12:0]} + {1'b0, sv_r};
    sv_carry = sv_sum >= {1'b0, sv_den};
    sv_rem   = sv_carry ? 13'(sv_sum - {1'b0, sv_den}) : sv_sum[12:0];
    sv_end   = sv_start + {1'b0, sv_q} + {13'd0, sv_carry};
  end

  bfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_pend_q <= 1'b1;
      setup_busy_q <= 1'b1;
      step_q       <= 3'd0;
    end else begin
      if (div_start) step_q <= start_step;
      if (cfg_we) begin
        setup_pend_q <= 1'b1;
        setup_busy_q <= 1'b1;
      end else begin
        if (setup_pend_q) setup_pend_q <= 1'b0;
        if (save && step_q == 3'd5) setup_busy_q <= 1'b0;
      end
    end
  end

  logic        accept, fs;
  logic [11:0] e_src_col, e_src_row, e_dst_col, e_dst_row;
  logic        e_first;
  logic [13:0] e_cstart, e_cend, e_rend;
  logic [12:0] e_crem, e_rrem;
  logic [12:0] col_p1, row_p1;
  logic        last_col_img, last_row_img, last_col_box, last_row_box;
  logic [13:0] csum, rsum;
  logic        ccarry, rcarry;
  logic [12:0] crem_n, rrem_n;
  logic [13:0] cend_n, rend_n;
  logic        init_c;
  logic [AW-1:0] idx_c;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !setup_busy_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign fs              = s_axis_tuser_i[0];

  always_comb begin
    e_src_col = fs ? 12'd0 : src_col_q;
    e_src_row = fs ? 12'd0 : src_row_q;
    e_dst_col = fs ? 12'd0 : dst_col_q;
    e_dst_row = fs ? 12'd0 : dst_row_q;
    e_first   = fs | first_q;
    e_cstart  = fs ? 14'd0 : cstart_q;
    e_cend    = fs ? {1'b0, qw_q} : cend_q;
    e_crem    = fs ? rw_q : crem_q;
    e_rend    = fs ? {1'b0, qh_q} : rend_q;
    e_rrem    = fs ? rh_q : rrem_q;

    col_p1       = {1'b0, e_src_col} + 13'd1;
    row_p1       = {1'b0, e_src_row} + 13'd1;
    last_col_img = col_p1 >= w_c;
    last_row_img = row_p1 >= h_c;
    last_col_box = last_col_img || ({1'b0, col_p1} >= e_cend);
    last_row_box = last_row_img || ({1'b0, row_p1} >= e_rend);

    // next box edge: add the integer step and carry the fraction
    csum   = {1'b0, e_crem} + {1'b0, rw_q};
    ccarry = csum >= {1'b0, dw_q};
    crem_n = ccarry ? 13'(csum - {1'b0, dw_q}) : csum[12:0];
    cend_n = e_cend + {1'b0, qw_q} + {13'd0, ccarry};
    rsum   = {1'b0, e_rrem} + {1'b0, rh_q};
    rcarry = rsum >= {1'b0, dh_q};
    rrem_n = rcarry ? 13'(rsum - {1'b0, dh_q}) : rsum[12:0];
    rend_n = e_rend + {1'b0, qh_q} + {13'd0, rcarry};

    init_c = e_first && ({2'b0, e_src_col} <= e_cstart);
    if ({3'b0, e_dst_col} > 15'(MAX_OUT_DIM - 1)) idx_c = AW'(MAX_OUT_DIM - 1);
    else idx_c = AW'(e_dst_col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      first_q   <= 1'b1;
      cstart_q  <= '0;
      cend_q    <= '0;
      crem_q    <= '0;
      rend_q    <= '0;
      rrem_q    <= '0;
      scale_q   <= 1'b0;
      dw_q      <= 13'd1;
      dh_q      <= 13'd1;
      qw_q      <= 13'd1;
      rw_q      <= '0;
      qh_q      <= 13'd1;
      rh_q      <= '0;
    end else if (save) begin
      case (step_q)
        3'd0: begin
          scale_q <= scale_c;
          if (!scale_c) dw_q <= w_c;
          else dw_q <= (div_quo == '0) ? 13'd1 : div_quo[12:0];
        end
        3'd1: begin
          if (!scale_c) dh_q <= h_c;
          else dh_q <= (div_quo == '0) ? 13'd1 : div_quo[12:0];
        end
        3'd2: begin
          qw_q <= div_quo[12:0];
          rw_q <= div_rem[12:0];
        end
        3'd3: begin
          qh_q <= div_quo[12:0];
          rh_q <= div_rem[12:0];
        end
        3'd4: begin
          cstart_q <= sv_start;
          cend_q   <= sv_end;
          crem_q   <= sv_rem;
        end
        default: begin
          rend_q <= sv_end;
          rrem_q <= sv_rem;
        end
      endcase
    end else if (accept) begin
      if (last_col_img) begin
        src_col_q <= '0;
        dst_col_q <= '0;
        cstart_q  <= '0;
        cend_q    <= {1'b0, qw_q};
        crem_q    <= rw_q;
        if (last_row_img) begin
          src_row_q <= '0;
          dst_row_q <= '0;
          first_q   <= 1'b1;
          rend_q    <= {1'b0, qh_q};
          rrem_q    <= rh_q;
        end else begin
          src_row_q <= row_p1[11:0];
          dst_row_q <= e_dst_row;
          rend_q    <= e_rend;
          rrem_q    <= e_rrem;
          first_q   <= last_row_box;
          if (last_row_box) begin
            dst_row_q <= e_dst_row + 12'd1;
            rend_q    <= rend_n;
            rrem_q    <= rrem_n;
          end
        end
      end else begin
        src_col_q <= col_p1[11:0];
        src_row_q <= e_src_row;
        dst_row_q <= e_dst_row;
        first_q   <= e_first;
        rend_q    <= e_rend;
        rrem_q    <= e_rrem;
        dst_col_q <= e_dst_col;
        cstart_q  <= e_cstart;
        cend_q    <= e_cend;
        crem_q    <= e_crem;
        if (last_col_box) begin
          dst_col_q <= e_dst_col + 12'd1;
          cstart_q  <= e_cend;
          cend_q    <= cend_n;
          crem_q    <= crem_n;
        end
      end
    end
  end

  // per-item request registers
  logic [7:0]    ch_q [4];
  logic          init_q, emit_q, fend_q;
  logic [11:0]   ocol_q, orow_q;
  logic [AW-1:0] idx_q;
  logic [2:0]    div_cnt_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        ch_q[i] <= (3'(i) < nch_c) ? s_axis_tdata_i[i*8 +: 8] : 8'd0;
      end
      init_q <= init_c;
      emit_q <= last_col_box && last_row_box;
      fend_q <= last_col_img && last_row_img;
      ocol_q <= e_dst_col;
      orow_q <= e_dst_row;
      idx_q  <= idx_c;
    end
  end

  // box counts and channel lanes
  logic [24:0] cnt_rd, cnt_new;
  lane_ctrl_t  lane_ctrl;
  logic [7:0]  avg [4];

  assign lane_ctrl.rd_en    = accept;
  assign lane_ctrl.acc_en   = state_q == ST_ACC;
  assign lane_ctrl.init     = init_q;
  assign lane_ctrl.div_step = state_q == ST_DIV;
  assign cnt_new            = init_q ? 25'd1 : cnt_rd + 25'd1;

  bfd_ram #(.WIDTH(25), .DEPTH(MAX_OUT_DIM), .AW(AW)) u_count (
    .clk_i   (clk_i),
    .we_i    (lane_ctrl.acc_en),
    .waddr_i (idx_q),
    .wdata_i (cnt_new),
    .re_i    (accept),
    .raddr_i (idx_c),
    .rdata_o (cnt_rd)
  );

  for (genvar g = 0; g < 4; g++) begin : g_lane
    bfd_lane #(.DEPTH(MAX_OUT_DIM), .AW(AW)) u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .rd_addr_i (idx_c),
      .wr_addr_i (idx_q),
      .chan_i    (ch_q[g]),
      .count_i   (cnt_new),
      .avg_o     (avg[g])
    );
  end

  // sequencer
  logic out_free;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = scale_q ? ST_ACC : ST_OUT;
      ST_ACC:  state_d = emit_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_cnt_q == 3'(AVG_STEPS - 1)) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 3'd1;
      else div_cnt_q <= '0;
    end
  end

  // merge lanes into the output register
  logic        m_valid_q;
  logic [87:0] m_data_q;
  logic        m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      if (scale_q) m_data_q[31:0] <= {avg[3], avg[2], avg[1], avg[0]};
      else m_data_q[31:0] <= {ch_q[3], ch_q[2], ch_q[1], ch_q[0]};
      m_data_q[87:32] <= {6'd0, dh_q, dw_q, orow_q, ocol_q};
      m_last_q        <= fend_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted pixel left sequencer idle");

  a_out_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_OUT))
    else $error("output request without sequencer");

  a_div_only_scaled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> scale_q && emit_q)
    else $error("average started on a pass-through pixel");

  a_no_accept_in_setup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> !s_axis_tready_o)
    else $error("input taken during size setup");
`endif

endmodule

// File: rtl/bfd_ram.sv
// ----------------------------------------------------------------------------
// bfd_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bfd_div.sv
// ----------------------------------------------------------------------------
// bfd_div
// Restoring radix-2 divider, one quotient bit per cycle, for size setup.
// ----------------------------------------------------------------------------
module bfd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bfd_pkg::DIV_NW-1:0] num_i,
  input  logic [bfd_pkg::DIV_DW-1:0] den_i,
  output logic                       done_o,
  output logic [bfd_pkg::DIV_NW-1:0] quo_o,
  output logic [bfd_pkg::DIV_DW-1:0] rem_o
);
  import bfd_pkg::*;

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [DIV_NW-1:0] num_q;
  logic [DIV_DW-1:0] den_q, rem_q, rem_d;
  logic [DIV_DW:0]   trial;
  logic              ge;

  always_comb begin
    trial = {rem_q, num_q[DIV_NW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[DIV_NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/bfd_lane.sv
// ----------------------------------------------------------------------------
// bfd_lane
// One channel lane: column sum store, accumulate and serial box average.
// ----------------------------------------------------------------------------
module bfd_lane #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                clk_i,
  input  bfd_pkg::lane_ctrl_t ctrl_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [7:0]          chan_i,
  input  logic [24:0]         count_i,
  output logic [7:0]          avg_o
);
  import bfd_pkg::*;

  logic [31:0] sum_rd, sum_new, rem_q;
  logic [39:0] dsr_q;
  logic [7:0]  quo_q;
  logic        zero_q;

  bfd_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_sum (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.acc_en),
    .waddr_i (wr_addr_i),
    .wdata_i (sum_new),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (sum_rd)
  );

  assign sum_new = ctrl_i.init ? {24'd0, chan_i} : sum_rd + {24'd0, chan_i};

  // quotient fits in 8 bits, so the divisor starts shifted up by seven
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      rem_q  <= sum_new;
      dsr_q  <= {8'd0, count_i, 7'd0};
      quo_q  <= '0;
      zero_q <= count_i == 25'd0;
    end else if (ctrl_i.div_step) begin
      if ({8'd0, rem_q} >= dsr_q) begin
        rem_q <= rem_q - dsr_q[31:0];
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        quo_q <= {quo_q[6:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
  end

  assign avg_o = zero_q ? 8'd0 : quo_q;

endmodule

// File: test/tb_box_filter_image_downscale_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_filter_image_downscale_core
// Drives raster pixels through several register settings, predicts every
// output pixel of the box filter downscaler and compares it field by field.
// ----------------------------------------------------------------------------

class box_avg_scoreboard;
  // register copies
  int unsigned cfg_w, cfg_h, cfg_nch, cfg_md;
  // column accumulators and position state
  int unsigned acc_sum[4][2048];
  int unsigned acc_cnt[2048];
  int unsigned src_col, src_row, dst_col, dst_row;
  bit          first_box_row;
  // expected output pixels, tdata and frame end
  logic [87:0] pend_data[$];
  bit          pend_last[$];
  int          mismatches;

  function new();
    cfg_w = 1024; cfg_h = 768; cfg_nch = 4; cfg_md = 1024;
    src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
    first_box_row = 1;
    mismatches = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [15:0] val);
    case (idx)
      bfd_pkg::CFG_SRC_WIDTH:  cfg_w = val[12:0];
      bfd_pkg::CFG_SRC_HEIGHT: cfg_h = val[12:0];
      bfd_pkg::CFG_CHANNELS:   cfg_nch = val[2:0];
      bfd_pkg::CFG_MAX_DIM:    cfg_md = val[11:0];
      default: ;
    endcase
  endfunction

  function longint unsigned clampv(longint unsigned v, longint unsigned lo,
                                   longint unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function longint unsigned out_side(longint unsigned side, longint unsigned md,
                                     longint unsigned longest);
    longint unsigned d;
    d = (2 * side * md + longest) / (2 * longest);
    return d == 0 ? 1 : d;
  endfunction

  // accepted input pixel: advance the predictor and queue any output pixel
  function void note_pixel(logic [31:0] pix, bit fs);
    longint unsigned w, h, nch, md, longest, dw, dh, cstart, cend, rend;
    bit scale, lci, lri, lcb, lrb, emit;
    int unsigned ch[4], res[4];
    int unsigned idx;
    logic [87:0] d;
    w = clampv(cfg_w, 1, 4096);
    h = clampv(cfg_h, 1, 4096);
    nch = clampv(cfg_nch, 1, 4);
    md = cfg_md > 2048 ? 2048 : cfg_md;
    longest = w > h ? w : h;
    scale = md != 0 && longest > md;
    dw = scale ? out_side(w, md, longest) : w;
    dh = scale ? out_side(h, md, longest) : h;
    for (int i = 0; i < 4; i++) begin
      ch[i] = (i < nch) ? pix[8*i +: 8] : 0;
      res[i] = ch[i];
    end
    if (fs) begin
      src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
      first_box_row = 1;
    end
    cstart = longint'(dst_col) * w / dw;
    cend = (longint'(dst_col) + 1) * w / dw;
    rend = (longint'(dst_row) + 1) * h / dh;
    lci = src_col + 1 >= w;
    lri = src_row + 1 >= h;
    lcb = lci || src_col + 1 >= cend;
    lrb = lri || src_row + 1 >= rend;
    emit = !scale || (lcb && lrb);
    if (scale) begin
      idx = dst_col < 2048 ? dst_col : 2047;
      if (first_box_row && src_col <= cstart) begin
        for (int i = 0; i < 4; i++) acc_sum[i][idx] = ch[i];
        acc_cnt[idx] = 1;
      end else begin
        for (int i = 0; i < 4; i++) acc_sum[i][idx] += ch[i];
        acc_cnt[idx] = (acc_cnt[idx] + 1) & 32'h1FF_FFFF;
      end
      for (int i = 0; i < 4; i++)
        res[i] = acc_cnt[idx] != 0 ? (acc_sum[i][idx] / acc_cnt[idx]) & 8'hFF : 0;
    end
    if (emit) begin
      d = '0;
      for (int i = 0; i < 4; i++) d[8*i +: 8] = res[i];
      d[43:32] = dst_col[11:0];
      d[55:44] = dst_row[11:0];
      d[68:56] = dw[12:0];
      d[81:69] = dh[12:0];
      pend_data.push_back(d);
      pend_last.push_back(lci && lri);
    end
    if (lci) begin
      src_col = 0; dst_col = 0;
      if (lri) begin
        src_row = 0; dst_row = 0; first_box_row = 1;
      end else begin
        src_row = (src_row + 1) & 12'hFFF;
        if (lrb) begin
          dst_row = (dst_row + 1) & 12'hFFF;
          first_box_row = 1;
        end else begin
          first_box_row = 0;
        end
      end
    end else begin
      src_col = (src_col + 1) & 12'hFFF;
      if (lcb) dst_col = (dst_col + 1) & 12'hFFF;
    end
  endfunction

  // accepted output pixel against the oldest expectation
  function void check_result(logic [87:0] data, logic last);
    logic [87:0] exp_d;
    bit exp_l, bad;
    int lo[9] = '{0, 8, 16, 24, 32, 44, 56, 69, 0};
    int wd[9] = '{8, 8, 8, 8, 12, 12, 13, 13, 0};
    if (pend_data.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output pixel %h last %b", data, last);
      return;
    end
    exp_d = pend_data.pop_front();
    exp_l = pend_last.pop_front();
    bad = exp_l != last;
    for (int f = 0; f < 8; f++)
      if (((exp_d ^ data) >> lo[f]) & ((88'd1 << wd[f]) - 1)) bad = 1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: exp ch %h col %0d row %0d size %0dx%0d last %b",
                  " | got ch %h col %0d row %0d size %0dx%0d last %b"},
                 exp_d[31:0], exp_d[43:32], exp_d[55:44], exp_d[68:56], exp_d[81:69],
                 exp_l, data[31:0], data[43:32], data[55:44], data[68:56], data[81:69],
                 last);
    end
  endfunction
endclass

module tb_box_filter_image_downscale_core;
  import bfd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;
  logic [0:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [87:0] m_data;
  logic        m_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  box_avg_scoreboard sb = new();
  int  send_idle_pct = 28;
  int  recv_idle_pct = 82;
  int  pixels_sent = 0;
  bit  rx_hold = 1'b0;
  int  cycles = 0;

  box_filter_image_downscale_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // output side with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data, m_last);
    m_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one long receiver hold-off while small boxes complete often
  initial begin
    wait (pixels_sent >= 1100);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (500) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic send_pixel(logic [31:0] pix, bit fs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= pix;
    s_user  <= fs;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sb.note_pixel(pix, fs);
    pixels_sent++;
    if (pixels_sent == 450) begin
      send_idle_pct = 82; recv_idle_pct = 28;
    end else if (pixels_sent == 900) begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    wait (sb.pend_data.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic run_phase(int w, int h, int nch, int md, int n);
    drain();
    write_reg(CFG_SRC_WIDTH, 16'(w));
    write_reg(CFG_SRC_HEIGHT, 16'(h));
    write_reg(CFG_CHANNELS, 16'(nch));
    write_reg(CFG_MAX_DIM, 16'(md));
    for (int k = 0; k < n; k++) begin
      send_pixel($urandom(), k == 0 || $urandom_range(0, 99) < 2);
      // sender waits for every pending result once
      if (w == 8191 && k == 150) drain();
    end
  endtask

  initial begin
    logic [31:0] dir_pix[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                32'h5555_5555, 32'hFF00_FF00, 32'h00FF_00FF,
                                32'h0102_0408, 32'h8040_2010};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // pass-through at the reset setting, extreme channel values
    for (int k = 0; k < 20; k++) send_pixel(dir_pix[k % 8], k == 0 || k == 9);
    run_phase(5, 4, 1, 0, 60);
    run_phase(7, 5, 4, 3, 150);
    run_phase(0, 0, 0, 1, 30);
    run_phase(8191, 1, 2, 2048, 300);
    run_phase(3, 9, 3, 2, 150);
    run_phase(10, 6, 7, 4095, 60);
    run_phase(16, 16, 4, 1, 300);
    run_phase(9, 6, 4, 5, 150);
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(0, 7),
                $urandom_range(0, 12), 50);
    drain();
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pend_data.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
